// ===== sv/bba_pkg.sv =====
// shared types and constants of the buddy block allocator
package bba_pkg;

  localparam int ORD_W   = 4;
  localparam int MODE_W  = 2;
  localparam int REQ_W   = 16;
  localparam int OFF_W   = 15;
  localparam int STAT_W  = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [ORD_W-1:0] POOL_ORDER_RST = 4'd8;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_RESET = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADREQ  = 2'd2,
    ST_BADOFF  = 2'd3
  } status_e;

  typedef enum logic [9:0] {
    S_INIT  = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_SCAN  = 10'b00_0000_0100,
    S_SHIFT = 10'b00_0000_1000,
    S_SPLIT = 10'b00_0001_0000,
    S_MARK  = 10'b00_0010_0000,
    S_FWR   = 10'b00_0100_0000,
    S_MRD   = 10'b00_1000_0000,
    S_MCHK  = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_e;

  typedef struct packed {
    logic init;
    logic accept;
    logic scan;
    logic shift;
    logic split;
    logic mark;
    logic fwr;
    logic mrd;
    logic mchk;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic imm;
    logic scan_end;
    logic scan_hit;
    logic is_free;
    logic go_shift;
    logic shift_end;
    logic split_end;
    logic merge_stop;
    logic merge_ok;
  } sts_t;

endpackage

// ===== sv/bba_in_if.sv =====
// request channel of the allocator
interface bba_in_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [REQ_W-1:0]  request_bytes;
  logic [OFF_W-1:0]  free_offset;

  modport source (output valid, mode, request_bytes, free_offset, input ready);
  modport sink   (input valid, mode, request_bytes, free_offset, output ready);
endinterface

// ===== sv/bba_out_if.sv =====
// response channel of the allocator
interface bba_out_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [OFF_W-1:0]  block_offset;
  logic [OFF_W-1:0]  block_last_byte;
  logic [OFF_W-1:0]  waste_bytes;

  modport source (output valid, status, block_offset, block_last_byte, waste_bytes,
                  input ready);
  modport sink   (input valid, status, block_offset, block_last_byte, waste_bytes,
                  output ready);
endinterface

// ===== sv/bba_ram.sv =====
// generic single write, single read ram with registered read data
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/bba_ctrl.sv =====
// sequencer of the allocator: one transaction at a time
module bba_ctrl import bba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign load        = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o        = '0;
    cmd_o.init   = (state_q == S_INIT);
    cmd_o.accept = (state_q == S_IDLE) && in_valid_i;
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.shift  = (state_q == S_SHIFT);
    cmd_o.split  = (state_q == S_SPLIT);
    cmd_o.mark   = (state_q == S_MARK);
    cmd_o.fwr    = (state_q == S_FWR);
    cmd_o.mrd    = (state_q == S_MRD);
    cmd_o.mchk   = (state_q == S_MCHK);
    cmd_o.load   = load;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) state_d = sts_i.imm ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_end) begin
          if (sts_i.scan_hit)      state_d = sts_i.is_free ? S_FWR : S_MARK;
          else if (sts_i.go_shift) state_d = S_SHIFT;
          else                     state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_end) state_d = sts_i.is_free ? S_MRD : S_SPLIT;
      end
      S_SPLIT: begin
        if (sts_i.split_end) state_d = S_DONE;
      end
      S_MARK:  state_d = S_DONE;
      S_FWR:   state_d = S_MRD;
      S_MRD:   state_d = sts_i.merge_stop ? S_DONE : S_MCHK;
      S_MCHK:  state_d = sts_i.merge_ok ? S_SHIFT : S_DONE;
      S_DONE: begin
        if (load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load)             out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

// ===== sv/bba_dp.sv =====
// datapath of the allocator: block table, scan, shift, split and merge
module bba_dp import bba_pkg::*; #(
  parameter int MAX_BLOCKS      = 256,
  parameter int MIN_BLOCK_BYTES = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [ORD_W-1:0]  pool_order_i,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [REQ_W-1:0]  request_bytes_i,
  input  logic [OFF_W-1:0]  free_offset_i,
  output logic [STAT_W-1:0] status_o,
  output logic [OFF_W-1:0]  block_offset_o,
  output logic [OFF_W-1:0]  block_last_byte_o,
  output logic [OFF_W-1:0]  waste_bytes_o
);
  localparam int TOP  = $clog2(MAX_BLOCKS + 1) - 1;
  localparam int SW   = $clog2(MAX_BLOCKS);
  localparam int AW   = $clog2(MAX_BLOCKS);
  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int MW   = CW + ORD_W;
  localparam int EW   = SW + ORD_W + 1;
  localparam int MINW = $clog2(MIN_BLOCK_BYTES + 1);
  localparam int BW0  = MINW + SW + 1;
  localparam int BW   = (BW0 > 17) ? BW0 : 17;
  localparam logic [BW-1:0]    MIN_B    = BW'(MIN_BLOCK_BYTES);
  localparam logic [CW-1:0]    MAX_C    = CW'(MAX_BLOCKS);
  localparam logic [ORD_W-1:0] TOP_O    = ORD_W'(TOP);
  localparam logic [ORD_W-1:0] INIT_ORD = (POOL_ORDER_RST > TOP_O) ? TOP_O : POOL_ORDER_RST;

  function automatic logic [EW-1:0] pack(input logic [SW-1:0] st, input logic [ORD_W-1:0] od,
                                         input logic u);
    return {st, od, u};
  endfunction

  // smallest order whose block holds the request
  function automatic logic [ORD_W-1:0] need_ord(input logic [REQ_W-1:0] r);
    logic [ORD_W-1:0] kk;
    kk = '0;
    for (int i = TOP; i >= 0; i--) begin
      if ((MIN_B << i) >= BW'(r)) kk = ORD_W'(i);
    end
    return kk;
  endfunction

  // table memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  bba_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_tab (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic [SW-1:0]    rd_start;
  logic [ORD_W-1:0] rd_ord;
  logic             rd_used;
  assign rd_start = rdata[EW-1:ORD_W+1];
  assign rd_ord   = rdata[ORD_W:1];
  assign rd_used  = rdata[0];

  // registers
  mode_e            mode_q, mode_d;
  logic [REQ_W-1:0] req_q, req_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [ORD_W-1:0] k_q, k_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pend_idx_q, pend_idx_d;
  logic             j_found_q, j_found_d;
  logic [AW-1:0]    j_idx_q, j_idx_d;
  logic [SW-1:0]    j_start_q, j_start_d;
  logic [ORD_W-1:0] j_order_q, j_order_d;
  logic [AW-1:0]    cur_idx_q, cur_idx_d;
  logic [SW-1:0]    cur_start_q, cur_start_d;
  logic [ORD_W-1:0] cur_order_q, cur_order_d;
  logic [AW-1:0]    src_q, src_d;
  logic [CW-1:0]    left_q, left_d;
  logic [ORD_W-1:0] dist_q, dist_d;
  logic             up_q, up_d;
  logic [ORD_W-1:0] sp_t_q, sp_t_d;
  logic [ORD_W-1:0] sp_ord_q, sp_ord_d;
  logic [AW-1:0]    lo_q, lo_d;
  logic             bud_lo_q, bud_lo_d;
  status_e          res_st_q, res_st_d;
  logic [OFF_W-1:0] res_off_q, res_off_d;
  logic [OFF_W-1:0] res_last_q, res_last_d;
  logic [OFF_W-1:0] res_waste_q, res_waste_d;
  logic [STAT_W-1:0] out_st_q, out_st_d;
  logic [OFF_W-1:0] out_off_q, out_off_d;
  logic [OFF_W-1:0] out_last_q, out_last_d;
  logic [OFF_W-1:0] out_waste_q, out_waste_d;

  // combinational helpers
  logic [ORD_W-1:0] eff;
  logic [BW-1:0]    pool_bytes;
  logic             bad_req;
  logic [BW-1:0]    rd_bytes;
  logic             ev, alloc_hit, larger, free_hit, hit, exhausted, issue_scan;
  logic [ORD_W-1:0] diff, s_val, fin_ord;
  logic [CW-1:0]    room;
  logic             go_shift, issue_sh;
  logic [AW-1:0]    sh_waddr;
  logic [BW-1:0]    a_off, a_size, a_last, a_waste, f_last;
  logic [SW-1:0]    sh_start, new_start;
  logic             buddy_below, merge_stop, merge_ok;

  assign eff        = (pool_order_i > TOP_O) ? TOP_O : pool_order_i;
  assign pool_bytes = MIN_B << eff;
  assign bad_req    = (request_bytes_i == '0) || (BW'(request_bytes_i) > pool_bytes);

  assign rd_bytes   = BW'(rd_start) * MIN_B;
  assign ev         = cmd_i.scan && pend_q;
  assign alloc_hit  = ev && (mode_q == MODE_ALLOC) && !rd_used && (rd_ord == k_q);
  assign larger     = ev && (mode_q == MODE_ALLOC) && !rd_used && (rd_ord > k_q);
  assign free_hit   = ev && (mode_q == MODE_FREE) && (rd_bytes == BW'(off_q));
  assign hit        = alloc_hit || free_hit;
  assign exhausted  = !pend_q && (idx_q >= count_q);
  assign issue_scan = cmd_i.scan && !hit && (idx_q < count_q);

  // number of splits, limited by table room
  assign diff     = j_order_q - k_q;
  assign room     = MAX_C - count_q;
  assign s_val    = (MW'(diff) < MW'(room)) ? diff : ORD_W'(room);
  assign go_shift = (mode_q == MODE_ALLOC) && j_found_q && (s_val != '0);
  assign fin_ord  = cur_order_q - dist_q;

  assign issue_sh = cmd_i.shift && (left_q != '0);
  assign sh_waddr = up_q ? AW'(CW'(pend_idx_q) + CW'(dist_q)) : (pend_idx_q - AW'(1));

  assign a_off   = BW'(cur_start_q) * MIN_B;
  assign a_size  = MIN_B << k_q;
  assign a_last  = a_off + a_size - BW'(1);
  assign a_waste = a_size - BW'(req_q);
  assign f_last  = BW'(off_q) + (MIN_B << cur_order_q) - BW'(1);

  // buddy lies below when the block's own size bit is set in its start
  assign sh_start    = cur_start_q >> cur_order_q;
  assign buddy_below = sh_start[0];
  assign merge_stop  = buddy_below ? (cur_idx_q == '0)
                                   : ((CW'(cur_idx_q) + CW'(1)) >= count_q);
  assign merge_ok    = (rd_ord == cur_order_q) && !rd_used;
  assign new_start   = bud_lo_q ? rd_start : cur_start_q;

  always_comb begin
    sts_o            = '0;
    sts_o.imm        = (mode_i == MODE_RESET) || (mode_i == MODE_NONE) ||
                       ((mode_i == MODE_ALLOC) && bad_req);
    sts_o.scan_end   = cmd_i.scan && (hit || exhausted);
    sts_o.scan_hit   = hit;
    sts_o.is_free    = (mode_q == MODE_FREE);
    sts_o.go_shift   = go_shift;
    sts_o.shift_end  = (left_q == '0) && !pend_q;
    sts_o.split_end  = (sp_t_q == '0);
    sts_o.merge_stop = merge_stop;
    sts_o.merge_ok   = merge_ok;
  end

  always_comb begin
    mode_d      = mode_q;
    req_d       = req_q;
    off_d       = off_q;
    k_d         = k_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    j_found_d   = j_found_q;
    j_idx_d     = j_idx_q;
    j_start_d   = j_start_q;
    j_order_d   = j_order_q;
    cur_idx_d   = cur_idx_q;
    cur_start_d = cur_start_q;
    cur_order_d = cur_order_q;
    src_d       = src_q;
    left_d      = left_q;
    dist_d      = dist_q;
    up_d        = up_q;
    sp_t_d      = sp_t_q;
    sp_ord_d    = sp_ord_q;
    lo_d        = lo_q;
    bud_lo_d    = bud_lo_q;
    res_st_d    = res_st_q;
    res_off_d   = res_off_q;
    res_last_d  = res_last_q;
    res_waste_d = res_waste_q;
    out_st_d    = out_st_q;
    out_off_d   = out_off_q;
    out_last_d  = out_last_q;
    out_waste_d = out_waste_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = idx_q[AW-1:0];

    if (cmd_i.init) begin
      we      = 1'b1;
      wdata   = pack('0, INIT_ORD, 1'b0);
      count_d = CW'(1);
    end

    if (cmd_i.accept) begin
      mode_d      = mode_e'(mode_i);
      req_d       = request_bytes_i;
      off_d       = free_offset_i;
      k_d         = need_ord(request_bytes_i);
      idx_d       = '0;
      j_found_d   = 1'b0;
      res_st_d    = (mode_e'(mode_i) == MODE_RESET) ? ST_OK : ST_BADREQ;
      res_off_d   = '0;
      res_last_d  = '0;
      res_waste_d = '0;
      if (mode_e'(mode_i) == MODE_RESET) begin
        we      = 1'b1;
        wdata   = pack('0, eff, 1'b0);
        count_d = CW'(1);
      end
    end

    if (cmd_i.scan) begin
      if (issue_scan) begin
        idx_d      = idx_q + CW'(1);
        pend_d     = 1'b1;
        pend_idx_d = idx_q[AW-1:0];
      end
      if (larger && !j_found_q) begin
        j_found_d = 1'b1;
        j_idx_d   = pend_idx_q;
        j_start_d = rd_start;
        j_order_d = rd_ord;
      end
      if (hit) begin
        cur_idx_d   = pend_idx_q;
        cur_start_d = rd_start;
        cur_order_d = rd_ord;
      end else if (exhausted) begin
        res_last_d  = '0;
        res_waste_d = '0;
        if (mode_q == MODE_FREE) begin
          res_st_d  = ST_BADOFF;
          res_off_d = off_q;
        end else if (go_shift) begin
          // open a gap of s entries above the block to split
          left_d      = count_q - CW'(j_idx_q) - CW'(1);
          src_d       = AW'(count_q - CW'(1));
          dist_d      = s_val;
          up_d        = 1'b1;
          count_d     = count_q + CW'(s_val);
          cur_idx_d   = j_idx_q;
          cur_start_d = j_start_q;
          cur_order_d = j_order_q;
          sp_t_d      = s_val;
          sp_ord_d    = j_order_q - ORD_W'(1);
        end else begin
          res_st_d  = ST_NOSPACE;
          res_off_d = '0;
        end
      end
    end

    if (cmd_i.shift) begin
      raddr = src_q;
      if (issue_sh) begin
        pend_d     = 1'b1;
        pend_idx_d = src_q;
        src_d      = up_q ? (src_q - AW'(1)) : (src_q + AW'(1));
        left_d     = left_q - CW'(1);
      end
      if (pend_q) begin
        we    = 1'b1;
        waddr = sh_waddr;
        wdata = rdata;
      end
    end

    if (cmd_i.split) begin
      we = 1'b1;
      if (sp_t_q != '0) begin
        // upper halves, largest first
        waddr    = AW'(CW'(cur_idx_q) + CW'(sp_t_q));
        wdata    = pack(cur_start_q + (SW'(1) << sp_ord_q), sp_ord_q, 1'b0);
        sp_t_d   = sp_t_q - ORD_W'(1);
        sp_ord_d = sp_ord_q - ORD_W'(1);
      end else begin
        waddr = cur_idx_q;
        wdata = pack(cur_start_q, fin_ord, fin_ord == k_q);
        if (fin_ord == k_q) begin
          res_st_d    = ST_OK;
          res_off_d   = a_off[OFF_W-1:0];
          res_last_d  = a_last[OFF_W-1:0];
          res_waste_d = a_waste[OFF_W-1:0];
        end else begin
          res_st_d    = ST_NOSPACE;
          res_off_d   = '0;
          res_last_d  = '0;
          res_waste_d = '0;
        end
      end
    end

    if (cmd_i.mark) begin
      we          = 1'b1;
      waddr       = cur_idx_q;
      wdata       = pack(cur_start_q, cur_order_q, 1'b1);
      res_st_d    = ST_OK;
      res_off_d   = a_off[OFF_W-1:0];
      res_last_d  = a_last[OFF_W-1:0];
      res_waste_d = a_waste[OFF_W-1:0];
    end

    if (cmd_i.fwr) begin
      we          = 1'b1;
      waddr       = cur_idx_q;
      wdata       = pack(cur_start_q, cur_order_q, 1'b0);
      res_st_d    = ST_OK;
      res_off_d   = off_q;
      res_last_d  = f_last[OFF_W-1:0];
      res_waste_d = '0;
    end

    if (cmd_i.mrd) begin
      raddr    = buddy_below ? (cur_idx_q - AW'(1)) : (cur_idx_q + AW'(1));
      lo_d     = buddy_below ? (cur_idx_q - AW'(1)) : cur_idx_q;
      bud_lo_d = buddy_below;
    end

    if (cmd_i.mchk && merge_ok) begin
      // merged block takes the lower slot, the upper slot is squeezed out
      we          = 1'b1;
      waddr       = lo_q;
      wdata       = pack(new_start, cur_order_q + ORD_W'(1), 1'b0);
      cur_idx_d   = lo_q;
      cur_start_d = new_start;
      cur_order_d = cur_order_q + ORD_W'(1);
      left_d      = count_q - CW'(lo_q) - CW'(2);
      src_d       = lo_q + AW'(2);
      up_d        = 1'b0;
      count_d     = count_q - CW'(1);
    end

    if (cmd_i.load) begin
      out_st_d    = res_st_q;
      out_off_d   = res_off_q;
      out_last_d  = res_last_q;
      out_waste_d = res_waste_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CW'(1);
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    req_q       <= req_d;
    off_q       <= off_d;
    k_q         <= k_d;
    idx_q       <= idx_d;
    pend_idx_q  <= pend_idx_d;
    j_found_q   <= j_found_d;
    j_idx_q     <= j_idx_d;
    j_start_q   <= j_start_d;
    j_order_q   <= j_order_d;
    cur_idx_q   <= cur_idx_d;
    cur_start_q <= cur_start_d;
    cur_order_q <= cur_order_d;
    src_q       <= src_d;
    left_q      <= left_d;
    dist_q      <= dist_d;
    up_q        <= up_d;
    sp_t_q      <= sp_t_d;
    sp_ord_q    <= sp_ord_d;
    lo_q        <= lo_d;
    bud_lo_q    <= bud_lo_d;
    res_st_q    <= res_st_d;
    res_off_q   <= res_off_d;
    res_last_q  <= res_last_d;
    res_waste_q <= res_waste_d;
    out_st_q    <= out_st_d;
    out_off_q   <= out_off_d;
    out_last_q  <= out_last_d;
    out_waste_q <= out_waste_d;
  end

  assign status_o          = out_st_q;
  assign block_offset_o    = out_off_q;
  assign block_last_byte_o = out_last_q;
  assign waste_bytes_o     = out_waste_q;
endmodule

// ===== sv/buddy_block_allocator.sv =====
// top level of the buddy block allocator
// The pool is MIN_BLOCK_BYTES << pool_order bytes and is kept as an address-ordered
// table of blocks (start, order, used) in one single-port-write, single-port-read
// ram of MAX_BLOCKS entries. One request is handled at a time. An allocate scans
// the table, one entry per cycle; when it has to split, it moves the entries above
// the chosen block up in one pass and then writes the new halves. A free scans for
// the block, then each merge reads the buddy and moves the entries above it down
// by one. Mode reset, mode none and bad requests skip the table walk and go
// straight to the result; the time of a heavy request on a full table is set by
// the single read port of the table. After reset the block writes the initial
// free block before it takes a request. pool_order sizes the table only at the
// next reset-pool request, though the bad-request check uses it at once. The
// result sits in an output register, so the next request is taken while the
// previous result still waits.
module buddy_block_allocator import bba_pkg::*; #(
  parameter int MAX_BLOCKS      = 256,
  parameter int MIN_BLOCK_BYTES = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  bba_in_if.sink             req_i,
  bba_out_if.source          rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);
  // configuration register: pool order at byte addresses zero to three (paddr[2] low)
  logic [ORD_W-1:0] pool_order_q, pool_order_d;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? '0 : PDATA_W'(pool_order_q);

  always_comb begin
    pool_order_d = pool_order_q;
    if (cfg_we) pool_order_d = pwdata[ORD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pool_order_q <= POOL_ORDER_RST;
    else         pool_order_q <= pool_order_d;
  end

  // controller and datapath
  cmd_t cmd;
  sts_t sts;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bba_dp #(
    .MAX_BLOCKS     (MAX_BLOCKS),
    .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .pool_order_i     (pool_order_q),
    .mode_i           (req_i.mode),
    .request_bytes_i  (req_i.request_bytes),
    .free_offset_i    (req_i.free_offset),
    .status_o         (rsp_o.status),
    .block_offset_o   (rsp_o.block_offset),
    .block_last_byte_o(rsp_o.block_last_byte),
    .waste_bytes_o    (rsp_o.waste_bytes)
  );
endmodule

// ===== test/buddy_block_allocator_tb.sv =====
// self-checking testbench of the buddy block allocator
module buddy_block_allocator_tb;
  import bba_pkg::*;

  localparam int UNIT       = 128;      // minimum block in bytes
  localparam int TBL_DEPTH  = 256;      // block table entries
  localparam int TOP_ORD    = 8;        // largest order the table can hold
  localparam int LIMIT      = 12000000; // cycles before the run is called hung
  localparam logic [PADDR_W-1:0] REG_POOL_ORDER = 3'd0;

  typedef struct packed {
    mode_e             mode;
    logic [REQ_W-1:0]  req;
    logic [OFF_W-1:0]  off;
  } alloc_req_t;

  typedef struct packed {
    status_e          status;
    logic [OFF_W-1:0] offset;
    logic [OFF_W-1:0] last;
    logic [OFF_W-1:0] waste;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic req_taken = 1'b0;

  bba_in_if  req_if ();
  bba_out_if rsp_if ();

  buddy_block_allocator dut (
    .clk_i(clk), .rst_ni(rst_n), .req_i(req_if.sink), .rsp_o(rsp_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the block table
  int         blk_start [TBL_DEPTH];
  int         blk_ord   [TBL_DEPTH];
  bit         blk_used  [TBL_DEPTH];
  int         blk_cnt;
  int         shadow_pool_order = 8;

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  int         errors = 0;
  int         cycles = 0;
  int         sender_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_asked = 0;

  function automatic int eff_order();
    return (shadow_pool_order > TOP_ORD) ? TOP_ORD : shadow_pool_order;
  endfunction

  function automatic void rebuild_table();
    blk_start[0] = 0;
    blk_ord[0]   = eff_order();
    blk_used[0]  = 1'b0;
    blk_cnt      = 1;
  endfunction

  function automatic alloc_rsp_t mk_rsp(status_e st, int off, int last, int waste);
    alloc_rsp_t r;
    r.status = st;
    r.offset = off[OFF_W-1:0];
    r.last   = last[OFF_W-1:0];
    r.waste  = waste[OFF_W-1:0];
    return r;
  endfunction

  function automatic alloc_rsp_t allocate_block(int req);
    int k, i, j, hit, size, off;
    k = 0;
    hit = -1;
    j = 0;
    if (req == 0 || req > (UNIT << eff_order())) return mk_rsp(ST_BADREQ, 0, 0, 0);
    while ((UNIT << k) < req) k++;
    for (i = 0; i < blk_cnt; i++)
      if (!blk_used[i] && blk_ord[i] == k) begin
        hit = i;
        break;
      end
    if (hit < 0) begin
      while (j < blk_cnt && (blk_used[j] || blk_ord[j] <= k)) j++;
      if (j >= blk_cnt) return mk_rsp(ST_NOSPACE, 0, 0, 0);
      // keep the lower half each time, push the upper half in right after it
      while (blk_ord[j] > k && blk_cnt < TBL_DEPTH) begin
        for (i = blk_cnt; i > j + 1; i--) begin
          blk_start[i] = blk_start[i-1];
          blk_ord[i]   = blk_ord[i-1];
          blk_used[i]  = blk_used[i-1];
        end
        blk_ord[j]--;
        blk_start[j+1] = blk_start[j] + (1 << blk_ord[j]);
        blk_ord[j+1]   = blk_ord[j];
        blk_used[j+1]  = 1'b0;
        blk_cnt++;
      end
      if (blk_ord[j] != k) return mk_rsp(ST_NOSPACE, 0, 0, 0);
      hit = j;
    end
    size = UNIT << k;
    off  = blk_start[hit] * UNIT;
    blk_used[hit] = 1'b1;
    return mk_rsp(ST_OK, off, off + size - 1, size - req);
  endfunction

  function automatic alloc_rsp_t release_block(int off);
    int e, last, o, lo, i;
    e = 0;
    while (e < blk_cnt && blk_start[e] * UNIT != off) e++;
    if (e >= blk_cnt) return mk_rsp(ST_BADOFF, off, 0, 0);
    last = off + (UNIT << blk_ord[e]) - 1;
    blk_used[e] = 1'b0;
    forever begin
      o = blk_ord[e];
      if ((blk_start[e] >> o) & 1) begin
        if (e == 0) break;
        lo = e - 1;
      end else begin
        if (e + 1 >= blk_cnt) break;
        lo = e;
      end
      if (blk_ord[lo] != o || blk_ord[lo+1] != o || blk_used[lo] || blk_used[lo+1]) break;
      blk_ord[lo] = o + 1;
      for (i = lo + 1; i < blk_cnt - 1; i++) begin
        blk_start[i] = blk_start[i+1];
        blk_ord[i]   = blk_ord[i+1];
        blk_used[i]  = blk_used[i+1];
      end
      blk_cnt--;
      e = lo;
    end
    return mk_rsp(ST_OK, off, last, 0);
  endfunction

  function automatic alloc_rsp_t predict_rsp(alloc_req_t r);
    unique case (r.mode)
      MODE_ALLOC: return allocate_block(int'(r.req));
      MODE_FREE:  return release_block(int'(r.off));
      MODE_RESET: begin
        rebuild_table();
        return mk_rsp(ST_OK, 0, 0, 0);
      end
      default:    return mk_rsp(ST_BADREQ, 0, 0, 0);
    endcase
  endfunction

  // monitor: predict on every accepted request, check every accepted response
  always @(posedge clk) begin
    alloc_req_t acc;
    alloc_rsp_t exp_r;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (req_if.valid && req_if.ready) begin
      acc.mode = mode_e'(req_if.mode);
      acc.req  = req_if.request_bytes;
      acc.off  = req_if.free_offset;
      expected_rsps.push_back(predict_rsp(acc));
    end
    if (rsp_if.valid && rsp_if.ready) begin
      if (expected_rsps.size() == 0) begin
        $error("response transaction with nothing expected");
        errors++;
      end else begin
        exp_r = expected_rsps.pop_front();
        if (rsp_if.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, rsp_if.status);
          errors++;
        end
        if (rsp_if.block_offset !== exp_r.offset) begin
          $error("block_offset: expected %0d, got %0d", exp_r.offset, rsp_if.block_offset);
          errors++;
        end
        if (rsp_if.block_last_byte !== exp_r.last) begin
          $error("block_last_byte: expected %0d, got %0d", exp_r.last,
                 rsp_if.block_last_byte);
          errors++;
        end
        if (rsp_if.waste_bytes !== exp_r.waste) begin
          $error("waste_bytes: expected %0d, got %0d", exp_r.waste, rsp_if.waste_bytes);
          errors++;
        end
      end
    end
  end

  // request handshake seen at the last rising edge
  always @(posedge clk) begin
    req_taken <= req_if.valid && req_if.ready;
  end

  // driver: hold a request until it is taken, then maybe idle
  initial begin
    req_if.valid = 1'b0;
    req_if.mode = '0;
    req_if.request_bytes = '0;
    req_if.free_offset = '0;
  end

  always @(negedge clk) begin
    alloc_req_t nxt;
    if (rst_n && (!req_if.valid || req_taken)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
        nxt = pending_reqs.pop_front();
        req_if.valid         <= 1'b1;
        req_if.mode          <= nxt.mode;
        req_if.request_bytes <= nxt.req;
        req_if.free_offset   <= nxt.off;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial rsp_if.ready = 1'b0;

  always @(negedge clk) begin
    int hold_left;
    int hold_seen;
    if (hold_asked != hold_seen) begin
      hold_seen = hold_asked;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  task automatic push_req(mode_e m, int req, int off);
    alloc_req_t r;
    r.mode = m;
    r.req  = req[REQ_W-1:0];
    r.off  = off[OFF_W-1:0];
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
      @(negedge clk);
  endtask

  // register writes only with the block idle, new order applied by a pool reset
  task automatic set_pool_order(int ord);
    wait_drained();
    @(negedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= REG_POOL_ORDER;
    pwdata <= ord;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_pool_order = ord & 15;
    push_req(MODE_RESET, 0, 0);
  endtask

  task automatic random_req();
    int pick, k, idx, tries;
    pick = $urandom_range(99, 0);
    if (pick < 48) begin
      k = $urandom_range($urandom_range(eff_order(), 0), 0);
      push_req(MODE_ALLOC, $urandom_range(UNIT << k, (k == 0) ? 1 : (UNIT << (k - 1)) + 1),
               $urandom);
    end else if (pick < 86) begin
      idx = $urandom_range(blk_cnt - 1, 0);
      for (tries = 0; tries < 6 && !blk_used[idx]; tries++)
        idx = $urandom_range(blk_cnt - 1, 0);
      push_req(MODE_FREE, $urandom, blk_start[idx] * UNIT);
    end else if (pick < 91) begin
      push_req(MODE_FREE, $urandom, $urandom_range(32767, 0));
    end else if (pick < 95) begin
      push_req(MODE_ALLOC, $urandom_range(65535, 0), $urandom);
    end else if (pick < 98) begin
      push_req(MODE_RESET, $urandom, $urandom);
    end else begin
      push_req(MODE_NONE, $urandom, $urandom);
    end
  endtask

  task automatic random_phase(int snd, int rcv, int ord, int n, bit press);
    set_pool_order(ord);
    sender_idle_pct = snd;
    recv_stall_pct  = rcv;
    for (int i = 0; i < n; i++) begin
      // generate one at a time so free offsets track the table state
      while (pending_reqs.size() > 0) @(negedge clk);
      if (press && i == n / 3) hold_asked++;
      if (press && i == 2 * n / 3) wait_drained();
      random_req();
    end
  endtask

  initial begin
    rebuild_table();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed corners at the reset pool order
    push_req(MODE_ALLOC, 0, 0);
    push_req(MODE_ALLOC, 32769, 0);
    push_req(MODE_ALLOC, 65535, 32767);
    push_req(MODE_ALLOC, 32768, 0);
    push_req(MODE_ALLOC, 1, 0);
    push_req(MODE_FREE, 0, 0);
    push_req(MODE_FREE, 0, 0);
    push_req(MODE_ALLOC, 1, 0);
    push_req(MODE_ALLOC, 128, 0);
    push_req(MODE_ALLOC, 200, 0);
    push_req(MODE_ALLOC, 16384, 0);
    push_req(MODE_ALLOC, 16384, 0);
    push_req(MODE_FREE, 0, 32767);
    push_req(MODE_FREE, 0, 64);
    push_req(MODE_FREE, 0, 128);
    push_req(MODE_FREE, 0, 0);
    push_req(MODE_FREE, 0, 256);
    push_req(MODE_NONE, 65535, 32767);
    push_req(MODE_RESET, 65535, 32767);
    push_req(MODE_ALLOC, 32768, 0);
    push_req(MODE_FREE, 0, 0);

    random_phase(0, 0, 8, 200, 1'b0);
    random_phase(75, 0, 3, 150, 1'b0);
    random_phase(0, 75, 15, 200, 1'b0);
    random_phase(7, 7, 1, 100, 1'b0);
    random_phase(0, 0, 8, 250, 1'b1);
    random_phase(7, 7, 5, 100, 1'b0);

    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
